### src/mctt_pkg.sv
// shared types and constants for the multi-channel tick timer
// used by multi_channel_tick_timer; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mctt_pkg;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_STOP  = 2'd1,
    OP_TICK  = 2'd2,
    OP_POP   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STATUS_OK             = 2'd0,
    STATUS_ALREADY_ACTIVE = 2'd1,
    STATUS_NOT_ACTIVE     = 2'd2,
    STATUS_QUEUE_EMPTY    = 2'd3
  } status_e;

  localparam int          IndexWidth = 4;
  localparam int          IntervalWidth = 32;
  localparam int          CountFieldWidth = 5;
  localparam logic [4:0]  CountFieldMax = 5'd31;
  localparam logic        TimerModeOneShot = 1'b1;

  // packed so that status lands in the lowest bits of the output item
  typedef struct packed {
    logic [IndexWidth-1:0]      popped_index;
    logic                       popped_valid;
    logic [CountFieldWidth-1:0] dropped_count;
    logic [CountFieldWidth-1:0] expired_count;
    status_e                    status;
  } result_t;

endpackage

`default_nettype wire

### src/mctt_ram.sv
// generic simple dual-port ram: one write port, one read port, registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module mctt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### src/multi_channel_tick_timer.sv
// channel   dir  tdata fields (low bit up)                         tuser
// s_axis    in   timer_index[3:0] interval_ticks[35:4]             operation[1:0]
//                one_shot[36], zero fill to 40 bits
// m_axis    out  status[1:0] expired_count[6:2] dropped_count[11:7] -
//                popped_valid[12] popped_index[16:13], fill to 24 bits
//
// start and stop go straight to the response state, pop first reads the queue ram,
// and a tick sweeps the timer ram one entry a cycle, read then write back
// one item is worked on at a time; the result sits in an output register
// so the next item is taken while it waits
// reset clears the run flags and queue pointers; rams need no clearing
// depends on mctt_pkg and mctt_ram
`timescale 1ns / 1ps
`default_nettype none

module multi_channel_tick_timer
  import mctt_pkg::*;
#(
  parameter int NUM_TIMERS  = 16,
  parameter int QUEUE_DEPTH = 16,
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // timer_index[3:0], interval_ticks[35:4], one_shot[36]
  input  wire logic [39:0] s_axis_tdata,
  // operation[1:0]
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // status[1:0], expired_count[6:2], dropped_count[11:7],
  // popped_valid[12], popped_index[16:13]
  output logic [23:0]      m_axis_tdata
);

  localparam int TW  = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int TCW = $clog2(NUM_TIMERS + 1);
  localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QFW = $clog2(QUEUE_DEPTH + 1);
  localparam int CW  = COUNT_WIDTH;
  localparam int RESW = $bits(result_t);

  typedef enum logic [1:0] {
    S_IDLE,
    S_TICK,
    S_POP,
    S_RESP
  } state_e;

  state_e                      state_q, state_d;
  logic [NUM_TIMERS-1:0]       running_q, running_d;
  logic [NUM_TIMERS-1:0]       single_q, single_d;
  logic [TCW-1:0]              iss_q, iss_d;
  logic                        pv_q, pv_d;
  logic [TW-1:0]               pidx_q, pidx_d;
  logic [QAW-1:0]              rptr_q, rptr_d;
  logic [QAW-1:0]              wptr_q, wptr_d;
  logic [QFW-1:0]              fill_q, fill_d;
  logic [CountFieldWidth-1:0]  exp_q, exp_d;
  logic [CountFieldWidth-1:0]  drop_q, drop_d;
  result_t                     res_q, res_d;
  result_t                     out_q, out_d;
  logic                        out_valid_q, out_valid_d;

  op_e                         in_op;
  logic [IndexWidth-1:0]       in_idx;
  logic [IntervalWidth-1:0]    in_ivl;
  logic                        in_single;
  logic [TW-1:0]               in_tidx;
  logic [CW-1:0]               in_cnt;

  logic                        t_we, t_re;
  logic [TW-1:0]               t_waddr, t_raddr;
  logic [2*CW-1:0]             t_wdata, t_rdata;
  logic [CW-1:0]               t_rem, t_ivl, t_rem_m1;
  logic                        q_we, q_re;
  logic [IndexWidth-1:0]       q_wdata, q_rdata;

  assign in_op     = op_e'(s_axis_tuser);
  assign in_idx    = s_axis_tdata[3:0];
  assign in_ivl    = s_axis_tdata[35:4];
  assign in_single = s_axis_tdata[36];
  assign in_tidx   = TW'(in_idx);
  assign in_cnt    = CW'(in_ivl);

  assign t_rem    = t_rdata[CW-1:0];
  assign t_ivl    = t_rdata[2*CW-1:CW];
  assign t_rem_m1 = t_rem - 1'b1;

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(24 - RESW)'(0), out_q};

  // interval in the upper half, remaining count in the lower half
  mctt_ram #(
    .WIDTH(2 * CW),
    .DEPTH(NUM_TIMERS)
  ) u_timer_ram (
    .clk_i  (clk_i),
    .we_i   (t_we),
    .waddr_i(t_waddr),
    .wdata_i(t_wdata),
    .re_i   (t_re),
    .raddr_i(t_raddr),
    .rdata_o(t_rdata)
  );

  mctt_ram #(
    .WIDTH(IndexWidth),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue_ram (
    .clk_i  (clk_i),
    .we_i   (q_we),
    .waddr_i(wptr_q),
    .wdata_i(q_wdata),
    .re_i   (q_re),
    .raddr_i(rptr_q),
    .rdata_o(q_rdata)
  );

  always_comb begin
    state_d     = state_q;
    running_d   = running_q;
    single_d    = single_q;
    iss_d       = iss_q;
    pv_d        = 1'b0;
    pidx_d      = pidx_q;
    rptr_d      = rptr_q;
    wptr_d      = wptr_q;
    fill_d      = fill_q;
    exp_d       = exp_q;
    drop_d      = drop_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    t_we        = 1'b0;
    t_waddr     = pidx_q;
    t_wdata     = {t_ivl, t_rem_m1};
    t_re        = 1'b0;
    t_raddr     = iss_q[TW-1:0];
    q_we        = 1'b0;
    q_wdata     = IndexWidth'(pidx_q);
    q_re        = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          res_d = '0;
          res_d.status = STATUS_OK;
          state_d = S_RESP;
          case (in_op)
            OP_START: begin
              if (32'(in_idx) >= NUM_TIMERS) begin
                res_d.status = STATUS_NOT_ACTIVE;
              end else if (running_q[in_tidx]) begin
                res_d.status = STATUS_ALREADY_ACTIVE;
              end else begin
                running_d[in_tidx] = 1'b1;
                single_d[in_tidx]  = in_single;
                t_we    = 1'b1;
                t_waddr = in_tidx;
                t_wdata = {in_cnt, in_cnt};
              end
            end
            OP_STOP: begin
              if (32'(in_idx) >= NUM_TIMERS || !running_q[in_tidx]) begin
                res_d.status = STATUS_NOT_ACTIVE;
              end else begin
                running_d[in_tidx] = 1'b0;
              end
            end
            OP_TICK: begin
              iss_d   = '0;
              exp_d   = '0;
              drop_d  = '0;
              state_d = S_TICK;
            end
            OP_POP: begin
              if (fill_q == '0) begin
                res_d.status = STATUS_QUEUE_EMPTY;
              end else begin
                q_re    = 1'b1;
                rptr_d  = (rptr_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
                fill_d  = fill_q - 1'b1;
                state_d = S_POP;
              end
            end
            default: begin
              res_d.status = STATUS_OK;
            end
          endcase
        end
      end

      S_TICK: begin
        // issue the read of one entry while the previous one is written back
        if (iss_q < TCW'(NUM_TIMERS)) begin
          t_re   = 1'b1;
          iss_d  = iss_q + 1'b1;
          pv_d   = 1'b1;
          pidx_d = iss_q[TW-1:0];
        end
        if (pv_q && running_q[pidx_q] && t_rem != '0) begin
          t_we = 1'b1;
          if (t_rem_m1 == '0) begin
            if (32'(fill_q) < QUEUE_DEPTH) begin
              q_we    = 1'b1;
              wptr_d  = (wptr_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
              fill_d  = fill_q + 1'b1;
              t_wdata = {t_ivl, t_ivl};
              exp_d   = (exp_q == CountFieldMax) ? exp_q : exp_q + 1'b1;
            end else begin
              // count stays at zero, the timer goes quiet
              drop_d  = (drop_q == CountFieldMax) ? drop_q : drop_q + 1'b1;
            end
            if (single_q[pidx_q] == TimerModeOneShot) begin
              running_d[pidx_q] = 1'b0;
            end
          end
        end
        if (iss_q == TCW'(NUM_TIMERS) && !pv_q) begin
          res_d.expired_count = exp_q;
          res_d.dropped_count = drop_q;
          state_d = S_RESP;
        end
      end

      S_POP: begin
        res_d.popped_valid = 1'b1;
        res_d.popped_index = q_rdata;
        state_d = S_RESP;
      end

      S_RESP: begin
        if (!out_valid_q || m_axis_tready) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      running_q   <= '0;
      single_q    <= '0;
      iss_q       <= '0;
      pv_q        <= 1'b0;
      rptr_q      <= '0;
      wptr_q      <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      running_q   <= running_d;
      single_q    <= single_d;
      iss_q       <= iss_d;
      pv_q        <= pv_d;
      rptr_q      <= rptr_d;
      wptr_q      <= wptr_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pidx_q <= pidx_d;
    exp_q  <= exp_d;
    drop_q <= drop_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(fill_q) <= QUEUE_DEPTH)
    else $error("queue fill beyond depth");

  a_tick_never_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_TICK |=> (running_q & ~$past(running_q)) == '0)
    else $error("timer started during a tick sweep");

  a_push_only_in_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_TICK |=> fill_q <= $past(fill_q))
    else $error("queue grew outside a tick");

  a_idle_no_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !pv_q)
    else $error("sweep entry pending while idle");
`endif

endmodule

`default_nettype wire

### tb/multi_channel_tick_timer_checker.sv
// checker for the multi-channel tick timer: predicts each result item from
// the accepted input items and compares it with what the block returns
// depends on mctt_pkg
`timescale 1ns / 1ps

module multi_channel_tick_timer_checker
  import mctt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  // timer_index[3:0], interval_ticks[35:4], one_shot[36]
  input  logic [39:0] s_tdata_i,
  // operation[1:0]
  input  logic [1:0]  s_tuser_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  // status[1:0], expired_count[6:2], dropped_count[11:7],
  // popped_valid[12], popped_index[16:13]
  input  logic [23:0] m_tdata_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          starts_o,
  output int          stops_o,
  output int          ticks_o,
  output int          pops_o,
  output int          expiries_o,
  output int          drops_o
);

  localparam int NumTimers  = 16;
  localparam int QueueDepth = 16;

  // shadow of the timer table and the expiry fifo
  logic                     running[NumTimers];
  logic                     one_shot[NumTimers];
  logic [IntervalWidth-1:0] period[NumTimers];
  logic [IntervalWidth-1:0] remaining[NumTimers];
  logic [IndexWidth-1:0]    expiry_fifo[QueueDepth];
  logic [IndexWidth-1:0]    rd_ptr;
  logic [IndexWidth-1:0]    wr_ptr;
  logic [4:0]               fill;

  result_t awaited_results[$];

  int mismatches;
  int n_start, n_stop, n_tick, n_pop, n_expired, n_dropped;

  assign fail_count_o = mismatches;
  assign starts_o     = n_start;
  assign stops_o      = n_stop;
  assign ticks_o      = n_tick;
  assign pops_o       = n_pop;
  assign expiries_o   = n_expired;
  assign drops_o      = n_dropped;

  task automatic predict_timer_result(input op_e op, input logic [IndexWidth-1:0] idx,
                                      input logic [IntervalWidth-1:0] ivl, input logic ss);
    result_t r;
    r        = '0;
    r.status = STATUS_OK;
    case (op)
      OP_START: begin
        n_start++;
        if (running[idx]) begin
          r.status = STATUS_ALREADY_ACTIVE;
        end else begin
          running[idx]   = 1'b1;
          one_shot[idx]  = ss;
          period[idx]    = ivl;
          remaining[idx] = ivl;
        end
      end
      OP_STOP: begin
        n_stop++;
        if (!running[idx]) r.status = STATUS_NOT_ACTIVE;
        else running[idx] = 1'b0;
      end
      OP_TICK: begin
        n_tick++;
        // ascending sweep; a dropped expiry leaves the count parked at zero
        for (int t = 0; t < NumTimers; t++) begin
          if (running[t] && remaining[t] != '0) begin
            remaining[t] = remaining[t] - 1'b1;
            if (remaining[t] == '0) begin
              if (fill < QueueDepth) begin
                expiry_fifo[wr_ptr] = IndexWidth'(t);
                wr_ptr              = wr_ptr + 1'b1;
                fill                = fill + 1'b1;
                remaining[t]        = period[t];
                r.expired_count     = r.expired_count + 1'b1;
              end else begin
                r.dropped_count = r.dropped_count + 1'b1;
              end
              if (one_shot[t] == TimerModeOneShot) running[t] = 1'b0;
            end
          end
        end
        n_expired += r.expired_count;
        n_dropped += r.dropped_count;
      end
      default: begin
        n_pop++;
        if (fill == '0) begin
          r.status = STATUS_QUEUE_EMPTY;
        end else begin
          r.popped_valid = 1'b1;
          r.popped_index = expiry_fifo[rd_ptr];
          rd_ptr         = rd_ptr + 1'b1;
          fill           = fill - 1'b1;
        end
      end
    endcase
    awaited_results.push_back(r);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t got;
    result_t want;
    if (!rst_ni) begin
      for (int t = 0; t < NumTimers; t++) begin
        running[t]  = 1'b0;
        one_shot[t] = 1'b0;
      end
      rd_ptr = '0;
      wr_ptr = '0;
      fill   = '0;
      awaited_results.delete();
      mismatches = 0;
      n_start    = 0;
      n_stop     = 0;
      n_tick     = 0;
      n_pop      = 0;
      n_expired  = 0;
      n_dropped  = 0;
      pending_o <= 0;
    end else begin
      // results belong to earlier items, so compare before predicting
      if (m_tvalid_i && m_tready_i) begin
        got = result_t'(m_tdata_i[16:0]);
        if (awaited_results.size() == 0) begin
          if (mismatches < 10) begin
            $display("%t unexpected result item %h, nothing awaited", $realtime, m_tdata_i);
          end
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          if (got.status !== want.status || got.expired_count !== want.expired_count ||
              got.dropped_count !== want.dropped_count ||
              got.popped_valid !== want.popped_valid ||
              got.popped_index !== want.popped_index) begin
            if (mismatches < 10) begin
              $display("%t mismatch: expected status %0d expired %0d dropped %0d pop %0d/%0d",
                       $realtime, want.status, want.expired_count, want.dropped_count,
                       want.popped_valid, want.popped_index);
              $display("%t           got      status %0d expired %0d dropped %0d pop %0d/%0d",
                       $realtime, got.status, got.expired_count, got.dropped_count,
                       got.popped_valid, got.popped_index);
            end
            mismatches++;
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        predict_timer_result(op_e'(s_tuser_i), s_tdata_i[3:0], s_tdata_i[35:4],
                             s_tdata_i[36]);
      end
      pending_o <= awaited_results.size();
    end
  end

endmodule

### tb/multi_channel_tick_timer_tb.sv
// top of the multi-channel tick timer testbench: clock, reset, stimulus,
// receiver stall pattern and verdict
// depends on mctt_pkg, multi_channel_tick_timer and the checker module
`timescale 1ns / 1ps

module multi_channel_tick_timer_tb;
  import mctt_pkg::*;

  localparam int RandomItems = 1826;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;

  int fail_count, pending, starts, stops, ticks, pops, expiries, drops;
  int burst_left = 0;
  int gap;

  always #5 clk_i = ~clk_i;

  multi_channel_tick_timer i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  multi_channel_tick_timer_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .s_tuser_i    (s_axis_tuser),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .starts_o     (starts),
    .stops_o      (stops),
    .ticks_o      (ticks),
    .pops_o       (pops),
    .expiries_o   (expiries),
    .drops_o      (drops)
  );

  // offer one item and hold it until taken; a burst ends in a random gap or in none
  task automatic offer_item(input op_e op, input logic [3:0] idx, input logic [31:0] ivl,
                            input logic ss);
    s_axis_tuser  <= op;
    s_axis_tdata  <= {3'b000, ss, ivl, idx};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  initial begin : stimulus
    int          profile, roll, w_start, w_stop, w_tick;
    op_e         op;
    logic [3:0]  idx;
    logic [31:0] ivl;
    logic        ss;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty pop, idle stop, restart of a running timer, extremes
    offer_item(OP_POP,   4'd0,  32'd0,         1'b0);
    offer_item(OP_STOP,  4'd5,  32'd0,         1'b0);
    offer_item(OP_START, 4'd0,  32'hFFFF_FFFF, 1'b0);
    offer_item(OP_START, 4'd0,  32'd1,         1'b1);
    offer_item(OP_START, 4'd15, 32'd1,         1'b1);
    offer_item(OP_START, 4'd7,  32'd0,         1'b0);   // zero interval never expires
    offer_item(OP_START, 4'd3,  32'd1,         1'b0);
    offer_item(OP_TICK,  4'd0,  32'd0,         1'b0);
    offer_item(OP_POP,   4'd0,  32'd0,         1'b0);
    offer_item(OP_POP,   4'd0,  32'd0,         1'b0);
    offer_item(OP_POP,   4'd0,  32'd0,         1'b0);
    offer_item(OP_STOP,  4'd0,  32'd0,         1'b0);
    offer_item(OP_STOP,  4'd7,  32'd0,         1'b0);
    offer_item(OP_STOP,  4'd15, 32'd0,         1'b0);   // single-shot already stopped
    // eight periodic timers of interval one: two ticks fill the queue, a third drops
    for (int t = 8; t < 15; t++) offer_item(OP_START, 4'(t), 32'd1, 1'b0);
    repeat (3) offer_item(OP_TICK, 4'd0, 32'd0, 1'b0);

    profile = 0;
    for (int n = 0; n < RandomItems; n++) begin
      if (n % 60 == 0) profile = $urandom_range(0, 3);
      case (profile)
        0:       begin w_start = 30; w_stop = 15; w_tick = 30; end  // balanced
        1:       begin w_start = 30; w_stop = 10; w_tick = 50; end  // queue overflows
        2:       begin w_start = 15; w_stop = 10; w_tick = 20; end  // mostly draining
        default: begin w_start = 40; w_stop = 35; w_tick = 15; end  // start/stop churn
      endcase
      roll = $urandom_range(0, 99);
      if (roll < w_start) op = OP_START;
      else if (roll < w_start + w_stop) op = OP_STOP;
      else if (roll < w_start + w_stop + w_tick) op = OP_TICK;
      else op = OP_POP;
      idx  = 4'($urandom_range(0, 15));
      ss   = 1'($urandom_range(0, 1));
      roll = $urandom_range(0, 99);
      if (op != OP_START || roll >= 90) ivl = $urandom();
      else if (roll < 10) ivl = 32'd0;
      else if (roll < 70) ivl = $urandom_range(1, 4);
      else ivl = $urandom_range(5, 30);
      offer_item(op, idx, ivl, ss);
    end
    s_axis_tvalid <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    $display("covered %0d starts, %0d stops, %0d ticks and %0d pops", starts, stops, ticks,
             pops);
    $display("%0d expiries queued, %0d lost to a full queue, %0d mismatches", expiries,
             drops, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // receiver: random modes of varying length, plus one long hold-off
  initial begin : receiver
    int cyc, mode, mode_left;
    cyc       = 0;
    mode      = 0;
    mode_left = 0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      @(posedge clk_i);
      cyc++;
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      if (cyc == 2500) begin
        // long stall so the block fills and backs up its input
        m_axis_tready <= 1'b0;
        for (int hold = 0; hold < 400; hold++) @(posedge clk_i);
      end else begin
        case (mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= 1'($urandom_range(0, 1));
          2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
          default: m_axis_tready <= ~m_axis_tready;
        endcase
      end
    end
  end

  initial begin : watchdog
    #5ms;
    $display("timeout with %0d results outstanding", pending);
    $display("== FAIL ==");
    $finish;
  end

endmodule

### multi_channel_tick_timer.f
src/mctt_pkg.sv
src/mctt_ram.sv
src/multi_channel_tick_timer.sv
tb/multi_channel_tick_timer_checker.sv
tb/multi_channel_tick_timer_tb.sv
